@@ design/edsm_pkg.sv @@
// ----------------------------------------------------------------------------
// Edit distance stream matcher package
// Field widths, command and register codes, and the control group that the
// core sends to every cell of the column chain.
// ----------------------------------------------------------------------------
package edsm_pkg;

  localparam int unsigned INDEX_W     = 4;
  localparam int unsigned SYMBOL_W    = 8;
  localparam int unsigned PLEN_W      = 5;
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = PLEN_W;

  // Request commands
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TEXT = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LOCAL_MODE     = 1'b1;

  localparam logic [PLEN_W-1:0] PLEN_RESET = 5'd16;

  typedef struct packed {
    logic                restart;
    logic                load;
    logic [INDEX_W-1:0]  idx;
    logic [SYMBOL_W-1:0] sym;
  } cell_ctrl_t;

endpackage

@@ design/edsm_item_if.sv @@
// ----------------------------------------------------------------------------
// Edit distance stream matcher request channel
// Valid/ready channel carrying one load or text request.
// ----------------------------------------------------------------------------
interface edsm_item_if import edsm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                command;
  logic [INDEX_W-1:0]  pattern_index;
  logic [SYMBOL_W-1:0] symbol;
  logic                last_symbol;

  modport source (output valid, command, pattern_index, symbol, last_symbol, input ready);
  modport sink   (input valid, command, pattern_index, symbol, last_symbol, output ready);
endinterface

@@ design/edsm_result_if.sv @@
// ----------------------------------------------------------------------------
// Edit distance stream matcher result channel
// Valid/ready channel carrying one distance per text request.
// ----------------------------------------------------------------------------
interface edsm_result_if #(
  parameter int unsigned DISTANCE_BITS = 16
) ();
  logic                     valid;
  logic                     ready;
  logic [DISTANCE_BITS-1:0] distance;
  logic                     final_result;

  modport source (output valid, distance, final_result, input ready);
  modport sink   (input valid, distance, final_result, output ready);
endinterface

@@ design/edsm_cell.sv @@
// ----------------------------------------------------------------------------
// Edit distance stream matcher cell
// Holds one pattern byte and one row of the current column. A wavefront token
// (text byte, cell above, diagonal) passes through and is handed on registered.
// ----------------------------------------------------------------------------
module edsm_cell import edsm_pkg::*; #(
  parameter int unsigned DISTANCE_BITS = 16,
  parameter int unsigned M_W           = 5,
  parameter int unsigned INDEX         = 0
) (
  input  logic                     clk,
  input  logic                     rst,
  input  cell_ctrl_t               ctrl,
  input  logic [M_W-1:0]           m,
  input  logic                     in_valid,
  input  logic [SYMBOL_W-1:0]      in_sym,
  input  logic [DISTANCE_BITS-1:0] in_up,
  input  logic [DISTANCE_BITS-1:0] in_diag,
  output logic                     out_valid,
  output logic [SYMBOL_W-1:0]      out_sym,
  output logic [DISTANCE_BITS-1:0] out_up,
  output logic [DISTANCE_BITS-1:0] out_diag
);

  localparam logic [M_W-1:0]     ROW      = M_W'(INDEX);
  localparam bit                 LOADABLE = INDEX < (1 << INDEX_W);
  localparam logic [INDEX_W-1:0] IDX_CODE = INDEX_W'(INDEX);
  localparam logic [DISTANCE_BITS:0] RV_WIDE = (DISTANCE_BITS+1)'(INDEX + 1);
  localparam logic [DISTANCE_BITS:0] DMAX_WIDE = {1'b0, {DISTANCE_BITS{1'b1}}};
  localparam logic [DISTANCE_BITS-1:0] RESET_VAL =
    (RV_WIDE > DMAX_WIDE) ? {DISTANCE_BITS{1'b1}} : RV_WIDE[DISTANCE_BITS-1:0];

  function automatic logic [DISTANCE_BITS-1:0] sat_inc(
    input logic [DISTANCE_BITS-1:0] a,
    input logic                     d
  );
    logic [DISTANCE_BITS:0] s;
    s = {1'b0, a} + {{DISTANCE_BITS{1'b0}}, d};
    return s[DISTANCE_BITS] ? {DISTANCE_BITS{1'b1}} : s[DISTANCE_BITS-1:0];
  endfunction

  logic [SYMBOL_W-1:0]      pat;
  logic [DISTANCE_BITS-1:0] col;
  logic                     active;
  logic [DISTANCE_BITS-1:0] from_up;
  logic [DISTANCE_BITS-1:0] from_left;
  logic [DISTANCE_BITS-1:0] from_diag;
  logic [DISTANCE_BITS-1:0] lo;
  logic [DISTANCE_BITS-1:0] v;

  assign active    = in_valid && (ROW < m);
  assign from_up   = sat_inc(in_up, 1'b1);
  assign from_left = sat_inc(col, 1'b1);
  assign from_diag = sat_inc(in_diag, pat != in_sym);
  assign lo        = (from_up < from_left) ? from_up : from_left;
  assign v         = (lo < from_diag) ? lo : from_diag;

  always_ff @(posedge clk) begin
    if (rst || ctrl.restart) begin
      col <= RESET_VAL;
    end else if (active) begin
      col <= v;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  // Rows beyond the pattern length pass the last active row straight on
  always_ff @(posedge clk) begin
    out_sym  <= in_sym;
    out_up   <= active ? v : in_up;
    out_diag <= active ? col : in_diag;
    if (LOADABLE && ctrl.load && ctrl.idx == IDX_CODE) begin
      pat <= ctrl.sym;
    end
  end

endmodule

@@ design/edit_distance_stream_matcher_core.sv @@
// ----------------------------------------------------------------------------
// Edit distance stream matcher core
// Unit-cost edit distance of a stored pattern against a streamed text.
// ----------------------------------------------------------------------------
// Requests arrive on item: a load request writes one pattern byte and clears
// the column; a text request advances the column by one text byte and gives
// one result on result (distance, plus final_result copied from last_symbol).
// The column lives in a chain of PATTERN_MAX cells, one row per cell; each
// text byte travels down the chain as a wavefront, one cell per cycle, through
// the launch register, the cells and the done register. One request is in the
// chain at a time; the next one is accepted once the last text result has left
// the done register, or straight after a load. A finished result moves into
// the output register while the next request runs; if the receiver holds ready
// low, a second result waits in the core and item.ready stays low until the
// output register frees up. Registers pattern_length and local_mode are
// written over cfg_we, cfg_index and cfg_data, by the user only while the core
// is idle; the core does not enforce this. Synchronous reset clears the top
// cell, resets the column and running best, sets pattern_length to 16 and
// local_mode to 0. Pattern bytes are not reset and must be loaded.
// ----------------------------------------------------------------------------
module edit_distance_stream_matcher_core import edsm_pkg::*; #(
  parameter int unsigned PATTERN_MAX   = 16,
  parameter int unsigned DISTANCE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  edsm_item_if.sink              item,
  edsm_result_if.source          result,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int unsigned M_W = $clog2(PATTERN_MAX + 1);
  localparam int unsigned M_RESET =
    (32'(PLEN_RESET) > PATTERN_MAX) ? PATTERN_MAX : 32'(PLEN_RESET);
  localparam logic [DISTANCE_BITS-1:0] BEST_RESET = DISTANCE_BITS'(M_RESET);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  logic [PLEN_W-1:0]        pattern_length;
  logic                     local_mode;
  logic [M_W-1:0]           m_eff;
  logic [DISTANCE_BITS-1:0] best_rst;
  logic [DISTANCE_BITS:0]   m_wide;

  logic [DISTANCE_BITS-1:0] top_cell;
  logic [DISTANCE_BITS-1:0] best;
  logic [DISTANCE_BITS-1:0] newtop;
  logic [DISTANCE_BITS:0]   top_inc;
  logic [DISTANCE_BITS-1:0] best_upd;
  logic [DISTANCE_BITS-1:0] exit_up;
  logic                     exit_valid;

  logic                     item_accept;
  logic                     is_text;
  logic                     out_free;
  cell_ctrl_t               cell_ctrl;

  logic                     launch_valid;
  logic [SYMBOL_W-1:0]      launch_sym;
  logic [DISTANCE_BITS-1:0] launch_up;
  logic [DISTANCE_BITS-1:0] launch_diag;
  logic                     last_r;

  logic [DISTANCE_BITS-1:0] done_dist;
  logic                     done_last;
  logic                     res_valid;
  logic [DISTANCE_BITS-1:0] res_dist;
  logic                     res_final;

  logic                     ch_valid [PATTERN_MAX+1];
  logic [SYMBOL_W-1:0]      ch_sym   [PATTERN_MAX+1];
  logic [DISTANCE_BITS-1:0] ch_up    [PATTERN_MAX+1];
  logic [DISTANCE_BITS-1:0] ch_diag  [PATTERN_MAX+1];

  // Pattern length in use, clamped to 1..PATTERN_MAX
  always_comb begin
    if (pattern_length == '0) begin
      m_eff = M_W'(1);
    end else if (32'(pattern_length) > PATTERN_MAX) begin
      m_eff = M_W'(PATTERN_MAX);
    end else begin
      m_eff = M_W'(pattern_length);
    end
  end

  assign m_wide   = (DISTANCE_BITS+1)'(m_eff);
  assign best_rst = m_wide[DISTANCE_BITS] ? {DISTANCE_BITS{1'b1}} : m_wide[DISTANCE_BITS-1:0];

  assign top_inc = {1'b0, top_cell} + (DISTANCE_BITS+1)'(1);
  assign newtop  = local_mode ? '0 :
                   (top_inc[DISTANCE_BITS] ? {DISTANCE_BITS{1'b1}} : top_inc[DISTANCE_BITS-1:0]);

  assign exit_valid = ch_valid[PATTERN_MAX];
  assign exit_up    = ch_up[PATTERN_MAX];
  assign best_upd   = (exit_up < best) ? exit_up : best;

  assign item_accept = item.valid && item.ready;
  assign is_text     = item.command == CMD_TEXT;
  assign out_free    = !res_valid || result.ready;

  always_comb begin
    cell_ctrl.restart = (item_accept && !is_text) || (exit_valid && last_r);
    cell_ctrl.load    = item_accept && !is_text;
    cell_ctrl.idx     = item.pattern_index;
    cell_ctrl.sym     = item.symbol;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (item_accept && is_text) begin
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        if (exit_valid) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      pattern_length <= PLEN_RESET;
      local_mode     <= 1'b0;
      top_cell       <= '0;
      best           <= BEST_RESET;
      launch_valid   <= 1'b0;
      res_valid      <= 1'b0;
    end else begin
      state        <= state_next;
      launch_valid <= item_accept && is_text;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_PATTERN_LENGTH: pattern_length <= cfg_data;
          CFG_LOCAL_MODE:     local_mode     <= cfg_data[0];
        endcase
      end
      if (item_accept && !is_text) begin
        top_cell <= '0;
        best     <= best_rst;
      end else if (item_accept) begin
        top_cell <= newtop;
      end else if (exit_valid) begin
        // Restart the column after the last text byte
        if (last_r) begin
          top_cell <= '0;
          best     <= best_rst;
        end else begin
          best <= best_upd;
        end
      end
      if (state == S_DONE && out_free) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_accept && is_text) begin
      launch_sym  <= item.symbol;
      launch_up   <= newtop;
      launch_diag <= top_cell;
      last_r      <= item.last_symbol;
    end
    if (state == S_RUN && exit_valid) begin
      done_dist <= local_mode ? best_upd : exit_up;
      done_last <= last_r;
    end
    if (state == S_DONE && out_free) begin
      res_dist  <= done_dist;
      res_final <= done_last;
    end
  end

  assign ch_valid[0] = launch_valid;
  assign ch_sym[0]   = launch_sym;
  assign ch_up[0]    = launch_up;
  assign ch_diag[0]  = launch_diag;

  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    edsm_cell #(
      .DISTANCE_BITS (DISTANCE_BITS),
      .M_W           (M_W),
      .INDEX         (k)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (cell_ctrl),
      .m         (m_eff),
      .in_valid  (ch_valid[k]),
      .in_sym    (ch_sym[k]),
      .in_up     (ch_up[k]),
      .in_diag   (ch_diag[k]),
      .out_valid (ch_valid[k+1]),
      .out_sym   (ch_sym[k+1]),
      .out_up    (ch_up[k+1]),
      .out_diag  (ch_diag[k+1])
    );
  end

  assign item.ready          = state == S_IDLE;
  assign result.valid        = res_valid;
  assign result.distance     = res_dist;
  assign result.final_result = res_final;

endmodule

@@ design/edsm_checker.sv @@
// ----------------------------------------------------------------------------
// Edit distance stream matcher checker
// Port-level checks on the core: reset, result ordering against text
// requests, and output hold under stall.
// ----------------------------------------------------------------------------
module edsm_checker import edsm_pkg::*; #(
  parameter int unsigned DISTANCE_BITS = 16
) (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     in_command,
  input logic                     res_valid,
  input logic                     res_ready,
  input logic [DISTANCE_BITS-1:0] res_distance,
  input logic                     res_final
);

  logic [2:0] outstanding;
  logic       text_accept;
  logic       res_accept;

  assign text_accept = in_valid && in_ready && in_command == CMD_TEXT;
  assign res_accept  = res_valid && res_ready;

  // Text requests taken but whose result is not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      outstanding <= outstanding + 3'(text_accept) - 3'(res_accept);
    end
  end

  a_reset_clears_result: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

  a_result_has_request: assert property (@(posedge clk) disable iff (rst)
    res_accept |-> outstanding != 3'd0)
    else $error("result without a pending text request");

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    outstanding <= 3'd2)
    else $error("more than two text requests in flight");

  a_full_blocks_input: assert property (@(posedge clk) disable iff (rst)
    outstanding == 3'd2 |-> !in_ready)
    else $error("request taken with chain and output register full");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_distance) && $stable(res_final))
    else $error("result changed while stalled");

endmodule

bind edit_distance_stream_matcher_core edsm_checker #(
  .DISTANCE_BITS (DISTANCE_BITS)
) u_edsm_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (item.valid),
  .in_ready     (item.ready),
  .in_command   (item.command),
  .res_valid    (result.valid),
  .res_ready    (result.ready),
  .res_distance (result.distance),
  .res_final    (result.final_result)
);
